[hdl/multilevel_queue_scheduler_top_macros.svh]
// ----------------------------------------------------------------------------
// multilevel queue scheduler assertion macros
// concurrent assertion shorthands used by the asserting scheduler top
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_QUEUE_SCHEDULER_TOP_MACROS_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_TOP_MACROS_SVH

// property that holds at every i_clk edge outside reset
`define MLQS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// consequent must hold in the i_clk cycle after the antecedent
`define MLQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mlqs_pkg.sv]
// ----------------------------------------------------------------------------
// mlqs_pkg
// shared widths, types and codes of the multilevel queue scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlqs_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int TIME_W    = 13;
    localparam int ARR_W     = 12;
    localparam int BURST_W   = 8;
    localparam int Q_W       = 4;

    localparam logic [Q_W-1:0] RR_QUANTUM_RESET = Q_W'(2);

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [TIME_W-1:0] t_time;

    typedef enum logic [0:0] {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SCAN,
        S_PICK,
        S_RESP,
        S_RUN,
        S_REM,
        S_TICK,
        S_FINCHK,
        S_TAT,
        S_WT
    } t_state;

endpackage

`default_nettype wire

[hdl/multilevel_queue_scheduler_top.sv]
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler_top
// two-level round robin over first come first served batch scheduler
// ----------------------------------------------------------------------------
// Jobs load one word per cycle while the block is idle; the word flagged
// last_job starts the batch run and the input stays not ready until the last
// result word has been loaded into the output register. The run is driven by
// a sequencer around one shared add/subtract unit: every admission pass walks
// the stored jobs one per cycle; a dispatch is a pass, pick, response, run,
// remain, tick, a second pass and a finish check; an empty tick a pass and a
// pick; each result passes the turnaround and waiting states, held by output
// stall. rr_quantum is written via the config port, kept from batch to batch.
`timescale 1ns / 1ps
`default_nettype none

`include "multilevel_queue_scheduler_top_macros.svh"

module multilevel_queue_scheduler_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mlqs_pkg::Q_W-1:0]      i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mlqs_pkg::ARR_W-1:0]    i_arrival_time,
    input  logic [mlqs_pkg::BURST_W-1:0]  i_burst_time,
    input  logic                          i_level,
    input  logic                          i_last_job,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mlqs_pkg::IDX_W-1:0]    o_job_index,
    output logic [mlqs_pkg::TIME_W-1:0]   o_completion_time,
    output logic [mlqs_pkg::TIME_W-1:0]   o_turnaround,
    output logic [mlqs_pkg::TIME_W-1:0]   o_waiting,
    output logic [mlqs_pkg::TIME_W-1:0]   o_response,
    output logic                          o_last_result
);
    import mlqs_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [Q_W-1:0]     r_quantum;
    t_cnt               r_job_count;
    t_cnt               r_done_count;
    t_time              r_tick;
    t_idx               r_scan_idx;
    logic               r_post;
    t_idx               r_job;
    logic [BURST_W-1:0] r_run;
    t_time              r_tat;
    t_idx               r_out_idx;
    logic [MAX_PROCS-1:0] r_started;
    logic [MAX_PROCS-1:0] r_admitted;

    logic [ARR_W-1:0]   r_arrival [MAX_PROCS];
    logic [BURST_W-1:0] r_burst   [MAX_PROCS];
    logic               r_lvl     [MAX_PROCS];
    logic [BURST_W-1:0] r_remain  [MAX_PROCS];
    t_time              r_finish  [MAX_PROCS];
    t_time              r_resp    [MAX_PROCS];

    logic  r_out_valid;
    t_idx  r_out_index;
    t_time r_out_completion;
    t_time r_out_turnaround;
    t_time r_out_waiting;
    t_time r_out_response;
    logic  r_out_last;

    logic               w_in_acc;
    logic               w_cfg_acc;
    logic               w_load_room;
    t_idx               w_load_idx;
    t_idx               w_addr;
    logic [ARR_W-1:0]   w_arr;
    logic [BURST_W-1:0] w_burst;
    logic               w_lvl;
    logic [BURST_W-1:0] w_rem;
    logic [Q_W-1:0]     w_q;
    logic               w_scan_last;
    logic               w_admit;
    logic               w_have_job;
    logic               w_fin;
    t_cnt               w_done_next;
    logic               w_out_load;
    logic               w_out_last;
    logic               w_idle_pick;
    logic               w_batch_idle;
    logic [CNT_W:0]     w_open_jobs;

    t_alu_op w_alu_op;
    t_time   w_alu_a;
    t_time   w_alu_b;
    t_time   w_alu_res;
    logic    w_alu_borrow;

    logic w_rr_push;
    logic w_fcfs_push;
    logic w_rr_pop;
    logic w_fcfs_pop;
    logic w_fifo_clear;
    t_idx w_rr_head;
    t_idx w_fcfs_head;
    t_cnt w_rr_count;
    t_cnt w_fcfs_count;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_LOAD);
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;

    assign w_load_room = (r_job_count < CNT_W'(MAX_PROCS));
    assign w_load_idx  = r_job_count[IDX_W-1:0];
    assign w_q         = (r_quantum == '0) ? Q_W'(1) : r_quantum;

    always_comb begin
        unique case (r_state)
            S_SCAN:       w_addr = r_scan_idx;
            S_TAT, S_WT:  w_addr = r_out_idx;
            default:      w_addr = r_job;
        endcase
    end

    assign w_arr   = r_arrival[w_addr];
    assign w_burst = r_burst[w_addr];
    assign w_lvl   = r_lvl[w_addr];
    assign w_rem   = r_remain[w_addr];

    assign w_scan_last = (CNT_W'(r_scan_idx) + CNT_W'(1)) == r_job_count;
    assign w_admit     = !r_admitted[w_addr] && !w_alu_borrow;
    assign w_have_job  = (w_rr_count != '0) || (w_fcfs_count != '0);
    assign w_fin       = (w_rem == '0);
    assign w_done_next = r_done_count + CNT_W'(w_fin);
    assign w_out_last  = (CNT_W'(r_out_idx) + CNT_W'(1)) == r_job_count;
    assign w_out_load  = (r_state == S_WT) && (!r_out_valid || i_out_ready);

    // checker views
    assign w_idle_pick  = (r_state == S_PICK) && !w_have_job;
    assign w_batch_idle = (r_job_count == '0) && (r_tick == '0) && (r_state == S_LOAD);
    assign w_open_jobs  = {1'b0, w_rr_count} + {1'b0, w_fcfs_count} + {1'b0, r_done_count};

    mlqs_alu u_alu (
        .i_op     (w_alu_op),
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .o_res    (w_alu_res),
        .o_borrow (w_alu_borrow)
    );

    mlqs_fifo u_rr_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_fifo_clear),
        .i_push      (w_rr_push),
        .i_push_data (w_addr),
        .i_pop       (w_rr_pop),
        .o_head      (w_rr_head),
        .o_count     (w_rr_count)
    );

    mlqs_fifo u_fcfs_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_fifo_clear),
        .i_push      (w_fcfs_push),
        .i_push_data (w_addr),
        .i_pop       (w_fcfs_pop),
        .o_head      (w_fcfs_head),
        .o_count     (w_fcfs_count)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && i_last_job) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_last) begin
                    n_state = r_post ? S_FINCHK : S_PICK;
                end
            end
            S_PICK:   n_state = w_have_job ? S_RESP : S_SCAN;
            S_RESP:   n_state = S_RUN;
            S_RUN:    n_state = S_REM;
            S_REM:    n_state = S_TICK;
            S_TICK:   n_state = S_SCAN;
            S_FINCHK: n_state = (w_done_next == r_job_count) ? S_TAT : S_SCAN;
            S_TAT:    n_state = S_WT;
            S_WT: begin
                if (w_out_load) begin
                    n_state = w_out_last ? S_LOAD : S_TAT;
                end
            end
            default:  n_state = S_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_alu_op     = ALU_ADD;
        w_alu_a      = '0;
        w_alu_b      = '0;
        w_rr_push    = 1'b0;
        w_fcfs_push  = 1'b0;
        w_rr_pop     = 1'b0;
        w_fcfs_pop   = 1'b0;
        w_fifo_clear = 1'b0;
        unique case (r_state)
            S_SCAN: begin
                w_alu_op    = ALU_SUB;
                w_alu_a     = r_tick;
                w_alu_b     = {{(TIME_W-ARR_W){1'b0}}, w_arr};
                w_rr_push   = w_admit && !w_lvl;
                w_fcfs_push = w_admit && w_lvl;
            end
            S_PICK: begin
                w_alu_op   = ALU_ADD;
                w_alu_a    = r_tick;
                w_alu_b    = TIME_W'(1);
                w_rr_pop   = (w_rr_count != '0);
                w_fcfs_pop = (w_rr_count == '0) && (w_fcfs_count != '0);
            end
            S_RESP: begin
                w_alu_op = ALU_SUB;
                w_alu_a  = r_tick;
                w_alu_b  = {{(TIME_W-ARR_W){1'b0}}, w_arr};
            end
            S_RUN: begin
                w_alu_op = ALU_SUB;
                w_alu_a  = {{(TIME_W-Q_W){1'b0}}, w_q};
                w_alu_b  = {{(TIME_W-BURST_W){1'b0}}, w_rem};
            end
            S_REM: begin
                w_alu_op = ALU_SUB;
                w_alu_a  = {{(TIME_W-BURST_W){1'b0}}, w_rem};
                w_alu_b  = {{(TIME_W-BURST_W){1'b0}}, r_run};
            end
            S_TICK: begin
                w_alu_op = ALU_ADD;
                w_alu_a  = r_tick;
                w_alu_b  = {{(TIME_W-BURST_W){1'b0}}, r_run};
            end
            S_FINCHK: begin
                w_rr_push = !w_fin && !w_lvl;
            end
            S_TAT: begin
                w_alu_op = ALU_SUB;
                w_alu_a  = r_finish[w_addr];
                w_alu_b  = {{(TIME_W-ARR_W){1'b0}}, w_arr};
            end
            S_WT: begin
                w_alu_op     = ALU_SUB;
                w_alu_a      = r_tat;
                w_alu_b      = {{(TIME_W-BURST_W){1'b0}}, w_burst};
                w_fifo_clear = w_out_load && w_out_last;
            end
            default: begin
                w_alu_op = ALU_ADD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_quantum    <= RR_QUANTUM_RESET;
            r_job_count  <= '0;
            r_done_count <= '0;
            r_tick       <= '0;
            r_scan_idx   <= '0;
            r_post       <= 1'b0;
            r_out_idx    <= '0;
            r_started    <= '0;
            r_admitted   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc) begin
                r_quantum <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (w_load_room) begin
                            r_job_count             <= r_job_count + CNT_W'(1);
                            r_started[w_load_idx]   <= 1'b0;
                            r_admitted[w_load_idx]  <= 1'b0;
                        end
                        r_scan_idx <= '0;
                        r_post     <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (w_admit) begin
                        r_admitted[w_addr] <= 1'b1;
                    end
                    r_scan_idx <= w_scan_last ? '0 : r_scan_idx + IDX_W'(1);
                end
                S_PICK: begin
                    if (!w_have_job) begin
                        r_tick <= w_alu_res;
                    end
                end
                S_RESP: begin
                    r_started[w_addr] <= 1'b1;
                end
                S_TICK: begin
                    r_tick     <= w_alu_res;
                    r_post     <= 1'b1;
                    r_scan_idx <= '0;
                end
                S_FINCHK: begin
                    r_done_count <= w_done_next;
                    r_post       <= 1'b0;
                    r_out_idx    <= '0;
                end
                S_WT: begin
                    if (w_out_load) begin
                        if (w_out_last) begin
                            r_job_count  <= '0;
                            r_done_count <= '0;
                            r_tick       <= '0;
                            r_started    <= '0;
                            r_admitted   <= '0;
                            r_out_idx    <= '0;
                        end else begin
                            r_out_idx <= r_out_idx + IDX_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // job stores and datapath words
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && w_load_room) begin
                    r_arrival[w_load_idx] <= i_arrival_time;
                    r_burst[w_load_idx]   <= i_burst_time;
                    r_lvl[w_load_idx]     <= i_level;
                    r_remain[w_load_idx]  <= i_burst_time;
                end
            end
            S_PICK: begin
                r_job <= (w_rr_count != '0) ? w_rr_head : w_fcfs_head;
            end
            S_RESP: begin
                if (!r_started[w_addr]) begin
                    r_resp[w_addr] <= w_alu_res;
                end
            end
            S_RUN: begin
                r_run <= (w_alu_borrow && !w_lvl) ? {{(BURST_W-Q_W){1'b0}}, w_q} : w_rem;
            end
            S_REM: begin
                r_remain[w_addr] <= w_alu_res[BURST_W-1:0];
            end
            S_FINCHK: begin
                if (w_fin) begin
                    r_finish[w_addr] <= r_tick;
                end
            end
            S_TAT: begin
                r_tat <= w_alu_res;
            end
            S_WT: begin
                if (w_out_load) begin
                    r_out_index      <= r_out_idx;
                    r_out_completion <= r_finish[w_addr];
                    r_out_turnaround <= r_tat;
                    r_out_waiting    <= w_alu_res;
                    r_out_response   <= r_resp[w_addr];
                    r_out_last       <= w_out_last;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_job_index       = r_out_index;
    assign o_completion_time = r_out_completion;
    assign o_turnaround      = r_out_turnaround;
    assign o_waiting         = r_out_waiting;
    assign o_response        = r_out_response;
    assign o_last_result     = r_out_last;

    `MLQS_ASSERT_ALWAYS(a_done_le_count, r_done_count <= r_job_count, "done over loaded")
    `MLQS_ASSERT_ALWAYS(a_queued_bound, (w_open_jobs <= {1'b0, r_job_count}), "queued over open")
    `MLQS_ASSERT_NEXT(a_idle_tick, w_idle_pick, r_tick == $past(r_tick) + TIME_W'(1), "idle tick")
    `MLQS_ASSERT_NEXT(a_batch_clear, w_fifo_clear, w_batch_idle && o_out_valid, "batch not clear")

endmodule

`default_nettype wire

[hdl/mlqs_alu.sv]
// ----------------------------------------------------------------------------
// mlqs_alu
// shared add / subtract unit, borrow out doubles as the compare result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlqs_alu (
    input  mlqs_pkg::t_alu_op i_op,
    input  mlqs_pkg::t_time   i_a,
    input  mlqs_pkg::t_time   i_b,
    output mlqs_pkg::t_time   o_res,
    output logic              o_borrow
);
    import mlqs_pkg::*;

    logic [TIME_W:0] w_sum;

    always_comb begin
        unique case (i_op)
            ALU_ADD: w_sum = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: w_sum = {1'b0, i_a} - {1'b0, i_b};
            default: w_sum = {1'b0, i_a} + {1'b0, i_b};
        endcase
    end

    assign o_res    = w_sum[TIME_W-1:0];
    assign o_borrow = w_sum[TIME_W];

endmodule

`default_nettype wire

[hdl/mlqs_fifo.sv]
// ----------------------------------------------------------------------------
// mlqs_fifo
// ready queue of job indexes, head visible without a pop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mlqs_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  logic           i_push,
    input  mlqs_pkg::t_idx i_push_data,
    input  logic           i_pop,
    output mlqs_pkg::t_idx o_head,
    output mlqs_pkg::t_cnt o_count
);
    import mlqs_pkg::*;

    t_idx r_mem [MAX_PROCS];
    t_idx r_head;
    t_idx r_tail;
    t_cnt r_count;

    logic w_do_push;
    logic w_do_pop;

    assign w_do_push = i_push && (r_count < CNT_W'(MAX_PROCS));
    assign w_do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_tail <= (r_tail == IDX_W'(MAX_PROCS - 1)) ? '0 : r_tail + IDX_W'(1);
            end
            if (w_do_pop) begin
                r_head <= (r_head == IDX_W'(MAX_PROCS - 1)) ? '0 : r_head + IDX_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_tail] <= i_push_data;
        end
    end

    assign o_head  = r_mem[r_head];
    assign o_count = r_count;

endmodule

`default_nettype wire
